// ----- src/icg_pkg.sv -----
package icg_pkg;

  // offset saturation and padding masks
  localparam logic [15:0] Mask16 = 16'hffff;
  localparam logic [15:0] Mask8  = 16'h00ff;

  // fixed offsets within the ip header
  localparam logic [15:0] OffIhl      = 16'd0;
  localparam logic [15:0] OffTotHi    = 16'd2;
  localparam logic [15:0] OffTotLo    = 16'd3;
  localparam logic [15:0] OffProto    = 16'd9;
  localparam logic [15:0] OffCsumHi   = 16'd10;
  localparam logic [15:0] OffCsumLo   = 16'd11;
  localparam logic [15:0] OffAddrLo   = 16'd12;
  localparam logic [15:0] OffAddrHi   = 16'd19;
  localparam logic [15:0] OffLenKnown = 16'd4;

  // tcp checksum field, relative to the segment start
  localparam logic [15:0] RelCsumHi = 16'd16;
  localparam logic [15:0] RelCsumLo = 16'd17;

  // depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueIdxW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // one classified request handed from front to back
  typedef struct packed {
    logic [15:0] hdr_word;
    logic [15:0] seg_word;
    logic [15:0] seg_len;
    logic        short_pkt;
    logic        last;
  } work_t;

  // one's-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ----- src/icg_front.sv -----
module icg_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  output logic           push_o,
  output icg_pkg::work_t push_data_o,
  input  logic           push_ready_i
);
  import icg_pkg::*;

  logic [15:0] offset_q, offset_d;
  logic [5:0]  hdr_bytes_q, hdr_bytes_d;
  logic [15:0] tot_len_q, tot_len_d;

  logic [15:0] hb_cur;
  logic [15:0] tl_cur;
  logic [15:0] word;
  logic [15:0] rel;
  logic [15:0] pseudo_word;
  logic        hdr_en;
  logic        seg_en;
  logic [16:0] received;
  logic        accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign push_o     = accept;

  // header fields as seen after this byte
  always_comb begin
    hdr_bytes_d = hdr_bytes_q;
    tot_len_d   = tot_len_q;
    if (offset_q == OffIhl) begin
      hdr_bytes_d = {data_byte_i[3:0], 2'b00};
    end else if (offset_q == OffTotHi) begin
      tot_len_d = {data_byte_i, tot_len_q[7:0]};
    end else if (offset_q == OffTotLo) begin
      tot_len_d = {tot_len_q[15:8], data_byte_i};
    end
    hb_cur = {10'd0, hdr_bytes_d};
    tl_cur = tot_len_d;
  end

  // classify the byte
  always_comb begin
    word = offset_q[0] ? ({8'd0, data_byte_i} & Mask8) : {data_byte_i, 8'd0};
    rel  = offset_q - hb_cur;
    hdr_en = (offset_q < hb_cur) && (offset_q != OffCsumHi) && (offset_q != OffCsumLo);
    seg_en = (offset_q >= hb_cur)
          && ((offset_q < OffLenKnown) || (offset_q < tl_cur))
          && (rel != RelCsumHi) && (rel != RelCsumLo);
    if (offset_q == OffProto) begin
      pseudo_word = {8'd0, data_byte_i};
    end else if ((offset_q >= OffAddrLo) && (offset_q <= OffAddrHi)) begin
      pseudo_word = word;
    end else begin
      pseudo_word = 16'd0;
    end
    received = {1'b0, offset_q} + 17'd1;

    push_data_o.hdr_word  = hdr_en ? word : 16'd0;
    push_data_o.seg_word  = oc_add(pseudo_word, seg_en ? word : 16'd0);
    push_data_o.seg_len   = tl_cur - hb_cur;
    push_data_o.short_pkt = received < {1'b0, tl_cur};
    push_data_o.last      = last_byte_i;
  end

  // offset and header field tracking, cleared after each packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      hdr_bytes_q <= '0;
      tot_len_q   <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        offset_q    <= '0;
        hdr_bytes_q <= '0;
        tot_len_q   <= '0;
      end else begin
        if (offset_q != Mask16) begin
          offset_q <= offset_q + 16'd1;
        end
        hdr_bytes_q <= hdr_bytes_d;
        tot_len_q   <= tot_len_d;
      end
    end
  end

endmodule

// ----- src/icg_queue.sv -----
module icg_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  icg_pkg::work_t push_data_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output icg_pkg::work_t pop_data_o,
  input  logic           pop_i
);
  import icg_pkg::*;

  work_t                mem_q [QueueDepth];
  logic [QueueIdxW-1:0] wr_ptr_q;
  logic [QueueIdxW-1:0] rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready_o = count_q != QueueCntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueueIdxW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueueIdxW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- src/icg_back.sv -----
module icg_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  icg_pkg::work_t pop_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [15:0]    ip_header_checksum_o,
  output logic [15:0]    tcp_segment_checksum_o,
  output logic           length_status_o
);
  import icg_pkg::*;

  logic [15:0] hdr_sum_q, hdr_sum_d;
  logic [15:0] seg_sum_q, seg_sum_d;
  logic        out_valid_q;
  logic [15:0] hdr_csum_q;
  logic [15:0] seg_csum_q;
  logic        status_q;
  logic        out_free;
  logic        do_pop;

  // a last request waits for the output register
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = pop_valid_i && (!pop_data_i.last || out_free);
  assign do_pop   = pop_o;

  // running sums
  always_comb begin
    hdr_sum_d = oc_add(hdr_sum_q, pop_data_i.hdr_word);
    seg_sum_d = oc_add(seg_sum_q, pop_data_i.seg_word);
  end

  // accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_sum_q <= '0;
      seg_sum_q <= '0;
    end else if (do_pop) begin
      if (pop_data_i.last) begin
        hdr_sum_q <= '0;
        seg_sum_q <= '0;
      end else begin
        hdr_sum_q <= hdr_sum_d;
        seg_sum_q <= seg_sum_d;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_pop && pop_data_i.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop && pop_data_i.last) begin
      hdr_csum_q <= ~hdr_sum_d;
      seg_csum_q <= ~oc_add(seg_sum_d, pop_data_i.seg_len);
      status_q   <= pop_data_i.short_pkt;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign ip_header_checksum_o   = hdr_csum_q;
  assign tcp_segment_checksum_o = seg_csum_q;
  assign length_status_o        = status_q;

endmodule

// ----- src/ipv4_tcp_checksum_generator.sv -----
// result path: registered in the queue, then in the output register, after its last byte is taken
// throughput: one packet byte per cycle; in_ready_o drops only while the two-entry queue is full
// a result waiting at the output stalls only the last byte of the next packet
// reset: rst_ni clears offset, header fields, sums, queue and output valid at once
module ipv4_tcp_checksum_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] ip_header_checksum_o,
  output logic [15:0] tcp_segment_checksum_o,
  output logic        length_status_o
);
  import icg_pkg::*;

  logic  push;
  work_t push_data;
  logic  push_ready;
  logic  pop_valid;
  work_t pop_data;
  logic  pop;

  // byte classification
  icg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  // decoupling queue
  icg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_i        (pop)
  );

  // accumulation and result
  icg_back u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .pop_valid_i            (pop_valid),
    .pop_data_i             (pop_data),
    .pop_o                  (pop),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .ip_header_checksum_o   (ip_header_checksum_o),
    .tcp_segment_checksum_o (tcp_segment_checksum_o),
    .length_status_o        (length_status_o)
  );

endmodule
